// ===== rtl/segment_intersection_point_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// Antecedent implies consequent on the next clock.
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same clock.
`define SIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sip_pkg.sv =====
package sip_pkg;
  localparam int OutBits = 32;
  localparam int StatBits = 2;

  typedef enum logic [StatBits-1:0] {
    ST_COMPUTED = 2'd0,
    ST_SHARED_A1 = 2'd1,
    ST_SHARED_A2 = 2'd2,
    ST_DEGENERATE = 2'd3
  } sip_status_t;
endpackage

// ===== rtl/sip_in_if.sv =====
interface sip_in_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;
  modport source (output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, input ready);
  modport sink (input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, output ready);
endinterface

// ===== rtl/sip_out_if.sv =====
interface sip_out_if;
  import sip_pkg::*;
  logic valid;
  logic ready;
  logic signed [OutBits-1:0] cross_x;
  logic signed [OutBits-1:0] cross_y;
  logic [StatBits-1:0] status;
  modport source (output valid, cross_x, cross_y, status, input ready);
  modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

// ===== rtl/sip_divider.sv =====
// Pipelined restoring divider: q = floor(num * 2^T_FRAC / den), num <= den.
// One quotient bit per stage, T_FRAC+1 stages; side data rides along.
module sip_divider
  import sip_pkg::*;
#(
  parameter int DW = 36,
  parameter int T_FRAC = 16,
  parameter int SW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [SW-1:0]     side_in,
  output logic              out_vld,
  output logic [T_FRAC:0]   quo,
  output logic [SW-1:0]     side_out
);
  localparam int NS = T_FRAC + 1;

  logic [DW:0]     rem_r  [NS];
  logic [DW-1:0]   den_r  [NS];
  logic [T_FRAC:0] q_r    [NS];
  logic [SW-1:0]   side_r [NS];
  logic [NS-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // First stage: integer bit
      if ({1'b0, num} >= {1'b0, den}) begin
        rem_r[0] <= {1'b0, num} - {1'b0, den};
        q_r[0]   <= (T_FRAC+1)'(1);
      end else begin
        rem_r[0] <= {1'b0, num};
        q_r[0]   <= '0;
      end
      den_r[0]  <= den;
      side_r[0] <= side_in;
      for (int i = 1; i < NS; i++) begin
        if ({rem_r[i-1][DW-1:0], 1'b0} >= {1'b0, den_r[i-1]}) begin
          rem_r[i] <= {rem_r[i-1][DW-1:0], 1'b0} - {1'b0, den_r[i-1]};
          q_r[i]   <= {q_r[i-1][T_FRAC-1:0], 1'b1};
        end else begin
          rem_r[i] <= {rem_r[i-1][DW-1:0], 1'b0};
          q_r[i]   <= {q_r[i-1][T_FRAC-1:0], 1'b0};
        end
        den_r[i]  <= den_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign quo      = q_r[NS-1];
  assign side_out = side_r[NS-1];
endmodule

// ===== rtl/segment_intersection_point.sv =====
// Segment intersection point. One segment pair per cycle is accepted while the
// pipeline is not stalled, and one result beat per pair is delivered in order.
// The pipeline has three front stages for differences, products, and cross
// products with absolute sums, one divider stage per quotient bit with T_FRAC+1
// stages, and two back stages: one for the scaled multiply, one for the add
// with saturation into the output register. The
// whole pipeline advances together whenever the output register is empty or
// its beat is being taken, so a stall holds every stage in place and nothing
// is lost or repeated. Results are signed fixed point with T_FRAC fraction
// bits, saturated to 32 bits. Status 1 or 2 returns the shared endpoint of A,
// status 3 flags a zero denominator and returns a1, status 0 is the computed
// crossing a1 + (a2-a1)*t.
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int T_FRAC = 16
) (
  input logic   clk,
  input logic   rst_n,
  sip_in_if.sink   in_ch,
  sip_out_if.source out_ch
);
  localparam int CW = COORD_BITS;
  localparam int DW1 = CW + 1;          // coordinate differences
  localparam int PW = 2 * DW1 + 1;      // cross product
  localparam int SUMW = PW + 1;         // d1 + d2
  localparam int AW = CW + T_FRAC + 1;  // scaled a1/a2
  localparam int MW = DW1 + T_FRAC + 2; // (a2-a1)*t
  localparam int RW = AW + MW + 1;      // final sum width
  localparam int SW = 2 * CW + 2 * DW1 + StatBits;

  // Hold the pipeline when the output register is full and not taken.
  logic adv;
  logic out_vld_r;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: differences and endpoint compares.
  logic s1_vld_r;
  logic signed [CW-1:0]  a1x_r1, a1y_r1, a2x_r1, a2y_r1;
  logic signed [DW1-1:0] bx_r1, by_r1, u1x_r1, u1y_r1, u2x_r1, u2y_r1;
  logic [StatBits-1:0] st_r1;
  logic sh1, sh2;

  assign sh1 = (in_ch.seg_a_start_x == in_ch.seg_b_start_x &&
                in_ch.seg_a_start_y == in_ch.seg_b_start_y) ||
               (in_ch.seg_a_start_x == in_ch.seg_b_end_x &&
                in_ch.seg_a_start_y == in_ch.seg_b_end_y);
  assign sh2 = (in_ch.seg_a_end_x == in_ch.seg_b_start_x &&
                in_ch.seg_a_end_y == in_ch.seg_b_start_y) ||
               (in_ch.seg_a_end_x == in_ch.seg_b_end_x &&
                in_ch.seg_a_end_y == in_ch.seg_b_end_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      a1x_r1 <= in_ch.seg_a_start_x;
      a1y_r1 <= in_ch.seg_a_start_y;
      a2x_r1 <= in_ch.seg_a_end_x;
      a2y_r1 <= in_ch.seg_a_end_y;
      bx_r1  <= DW1'(in_ch.seg_b_end_x) - DW1'(in_ch.seg_b_start_x);
      by_r1  <= DW1'(in_ch.seg_b_end_y) - DW1'(in_ch.seg_b_start_y);
      u1x_r1 <= DW1'(in_ch.seg_a_start_x) - DW1'(in_ch.seg_b_start_x);
      u1y_r1 <= DW1'(in_ch.seg_a_start_y) - DW1'(in_ch.seg_b_start_y);
      u2x_r1 <= DW1'(in_ch.seg_a_end_x) - DW1'(in_ch.seg_b_start_x);
      u2y_r1 <= DW1'(in_ch.seg_a_end_y) - DW1'(in_ch.seg_b_start_y);
      st_r1  <= sh1 ? ST_SHARED_A1 : (sh2 ? ST_SHARED_A2 : ST_COMPUTED);
    end
  end

  // Stage 2: four products.
  logic s2_vld_r;
  logic signed [CW-1:0] a1x_r2, a1y_r2, a2x_r2, a2y_r2;
  logic signed [2*DW1-1:0] p1a_r2, p1b_r2, p2a_r2, p2b_r2;
  logic [StatBits-1:0] st_r2;

  always_ff @(posedge clk) begin
    if (adv) begin
      a1x_r2 <= a1x_r1;
      a1y_r2 <= a1y_r1;
      a2x_r2 <= a2x_r1;
      a2y_r2 <= a2y_r1;
      p1a_r2 <= bx_r1 * u1y_r1;
      p1b_r2 <= by_r1 * u1x_r1;
      p2a_r2 <= bx_r1 * u2y_r1;
      p2b_r2 <= by_r1 * u2x_r1;
      st_r2  <= st_r1;
    end
  end

  // Stage 3: cross products, absolute values, denominator.
  logic s3_vld_r;
  logic signed [PW-1:0] c1, c2;
  logic [PW-1:0] d1_a, d2_a;
  logic [SUMW-1:0] d1_r3, den_r3;
  logic [SW-1:0] side_r3;
  logic [StatBits-1:0] st3;

  assign c1 = PW'(p1a_r2) - PW'(p1b_r2);
  assign c2 = PW'(p2a_r2) - PW'(p2b_r2);
  assign d1_a = c1[PW-1] ? PW'(-c1) : PW'(c1);
  assign d2_a = c2[PW-1] ? PW'(-c2) : PW'(c2);

  always_comb begin
    st3 = st_r2;
    if (st_r2 == ST_COMPUTED && d1_a == '0 && d2_a == '0) begin
      st3 = ST_DEGENERATE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r3   <= SUMW'(d1_a);
      den_r3  <= SUMW'(d1_a) + SUMW'(d2_a);
      side_r3 <= {a1x_r2, a1y_r2, DW1'(a2x_r2) - DW1'(a1x_r2),
                  DW1'(a2y_r2) - DW1'(a1y_r2), st3};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Divider: t = floor(d1 * 2^T_FRAC / (d1+d2)).
  logic dv_vld;
  logic [T_FRAC:0] t_q;
  logic [SW-1:0] dv_side;

  sip_divider #(.DW(SUMW), .T_FRAC(T_FRAC), .SW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s3_vld_r),
    .num      (d1_r3),
    .den      (den_r3),
    .side_in  (side_r3),
    .out_vld  (dv_vld),
    .quo      (t_q),
    .side_out (dv_side)
  );

  logic signed [CW-1:0]  dv_a1x, dv_a1y;
  logic signed [DW1-1:0] dv_dx, dv_dy;
  logic [StatBits-1:0]   dv_st;
  assign {dv_a1x, dv_a1y, dv_dx, dv_dy, dv_st} = dv_side;

  // Stage M: scale the direction by t; pick the base point.
  logic m_vld_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [AW-1:0] bxs_r, bys_r;
  logic [StatBits-1:0] m_st_r;
  logic signed [MW-1:0] t_s;
  assign t_s = MW'($signed({1'b0, t_q}));

  always_ff @(posedge clk) begin
    if (adv) begin
      m_st_r <= dv_st;
      if (dv_st == ST_COMPUTED) begin
        mx_r <= MW'(MW'(dv_dx) * t_s);
        my_r <= MW'(MW'(dv_dy) * t_s);
      end else begin
        mx_r <= '0;
        my_r <= '0;
      end
      if (dv_st == ST_SHARED_A2) begin
        bxs_r <= AW'(dv_a1x) + AW'(dv_dx);
        bys_r <= AW'(dv_a1y) + AW'(dv_dy);
      end else begin
        bxs_r <= AW'(dv_a1x);
        bys_r <= AW'(dv_a1y);
      end
    end
  end

  // Output stage: shift, add, saturate.
  logic signed [RW-1:0] sx, sy;
  logic signed [OutBits-1:0] ox, oy;
  logic signed [OutBits-1:0] out_x_r, out_y_r;
  logic [StatBits-1:0] out_st_r;

  assign sx = (RW'(bxs_r) <<< T_FRAC) + RW'(mx_r);
  assign sy = (RW'(bys_r) <<< T_FRAC) + RW'(my_r);

  function automatic logic signed [OutBits-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] mx, mn;
    mx = RW'({1'b0, {(OutBits-1){1'b1}}});
    mn = -mx - RW'(1);
    if (v > mx) return mx[OutBits-1:0];
    if (v < mn) return mn[OutBits-1:0];
    return v[OutBits-1:0];
  endfunction

  assign ox = sat(sx);
  assign oy = sat(sy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r   <= dv_vld;
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r  <= ox;
      out_y_r  <= oy;
      out_st_r <= m_st_r;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.cross_x = out_x_r;
  assign out_ch.cross_y = out_y_r;
  assign out_ch.status  = out_st_r;
endmodule

// ===== rtl/sip_checker.sv =====
`include "segment_intersection_point_macros.svh"
module sip_assertions
  import sip_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic in_ready,
  input logic signed [OutBits-1:0] cross_x,
  input logic [StatBits-1:0] status
);
  // A pending beat holds.
  `SIP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(cross_x) && $stable(status),
                   "stalled beat changed")
  // The block takes input whenever its output is free.
  `SIP_ASSERT_NOW(a_rdy, clk, rst_n, !out_valid || out_ready, in_ready,
                  "input stalled needlessly")
  // Stall means stall.
  `SIP_ASSERT_NOW(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready,
                  "accepted while stalled")
endmodule

bind segment_intersection_point sip_assertions u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .in_ready  (in_ch.ready),
  .cross_x   (out_ch.cross_x),
  .status    (out_ch.status)
);

// ===== dv/sip_checker.sv =====
`timescale 1ns / 100ps

module sip_checker
  import sip_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int T_FRAC = 16
) (
  input  logic clk,
  input  logic rst_n,
  sip_in_if    in_ch,
  sip_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   beats_checked,
  output int   degenerate_seen
);

  typedef struct {
    logic signed [OutBits-1:0] x;
    logic signed [OutBits-1:0] y;
    sip_status_t               st;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Fixed-point crossing of segment A with segment B.
  function automatic crossing_t crossing_of(
    input longint ax1, input longint ay1, input longint ax2, input longint ay2,
    input longint bx1, input longint by1, input longint bx2, input longint by2);
    crossing_t c;
    longint    unit, dirx, diry, near_d, far_d, sum_d, t, px, py;
    unit = longint'(1) <<< T_FRAC;
    px = ax1 * unit;
    py = ay1 * unit;
    if ((ax1 == bx1 && ay1 == by1) || (ax1 == bx2 && ay1 == by2)) begin
      c.st = ST_SHARED_A1;
    end else if ((ax2 == bx1 && ay2 == by1) || (ax2 == bx2 && ay2 == by2)) begin
      c.st = ST_SHARED_A2;
      px = ax2 * unit;
      py = ay2 * unit;
    end else begin
      dirx = bx2 - bx1;
      diry = by2 - by1;
      near_d = abs64(dirx * (ay1 - by1) - diry * (ax1 - bx1));
      far_d = abs64(dirx * (ay2 - by2 + diry) - diry * (ax2 - bx2 + dirx));
      sum_d = near_d + far_d;
      if (sum_d == 0) begin
        c.st = ST_DEGENERATE;
      end else begin
        c.st = ST_COMPUTED;
        t = (near_d <<< T_FRAC) / sum_d;
        px = px + (ax2 - ax1) * t;
        py = py + (ay2 - ay1) * t;
      end
    end
    c.x = OutBits'(clamp32(px));
    c.y = OutBits'(clamp32(py));
    return c;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  assign pending = crossing_q.size();

  initial begin
    fail_count = 0;
    beats_checked = 0;
    degenerate_seen = 0;
  end

  // Sample mid-cycle: handshakes seen here complete at the next rising edge.
  always @(negedge clk) begin
    crossing_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        crossing_q.push_back(crossing_of(
          in_ch.seg_a_start_x, in_ch.seg_a_start_y, in_ch.seg_a_end_x, in_ch.seg_a_end_y,
          in_ch.seg_b_start_x, in_ch.seg_b_start_y, in_ch.seg_b_end_x, in_ch.seg_b_end_y));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = crossing_q.pop_front();
          beats_checked++;
          if (want.st == ST_DEGENERATE) degenerate_seen++;
          if (out_ch.cross_x !== want.x) report_mismatch("cross_x", out_ch.cross_x, want.x);
          if (out_ch.cross_y !== want.y) report_mismatch("cross_y", out_ch.cross_y, want.y);
          if (out_ch.status !== want.st) report_mismatch("status", out_ch.status, want.st);
        end
      end
    end
  end

endmodule

// ===== dv/tb_segment_intersection_point.sv =====
`timescale 1ns / 100ps

module tb_segment_intersection_point;
  import sip_pkg::*;

  localparam int CB = 16;
  localparam int TF = 16;
  localparam int RandomPairs = 800;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, beats_checked, degenerate_seen;
  bit   burst_mode = 1'b0;

  sip_in_if #(.COORD_BITS(CB)) in_ch ();
  sip_out_if out_ch ();

  segment_intersection_point #(.COORD_BITS(CB), .T_FRAC(TF)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  sip_checker #(.COORD_BITS(CB), .T_FRAC(TF)) i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending),
    .beats_checked(beats_checked), .degenerate_seen(degenerate_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run once the cycle count passes CycleLimit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Draw the wait before the next beat; burst mode drops all idling.
  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 6);
  endfunction

  // Drive one segment pair and hold it until the block takes the beat.
  task automatic send_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                           input int bx1, input int by1, input int bx2, input int by2);
    int  gap;
    bit  taken;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.seg_a_start_x <= CB'(ax1);
    in_ch.seg_a_start_y <= CB'(ay1);
    in_ch.seg_a_end_x <= CB'(ax2);
    in_ch.seg_a_end_y <= CB'(ay2);
    in_ch.seg_b_start_x <= CB'(bx1);
    in_ch.seg_b_start_y <= CB'(by1);
    in_ch.seg_b_end_x <= CB'(bx2);
    in_ch.seg_b_end_y <= CB'(by2);
    forever begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  function automatic int any_coord();
    return int'($signed(CB'($urandom)));
  endfunction

  function automatic int near_coord(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Result side: stall a random number of cycles before each beat.
  initial begin
    int  stall;
    bit  taken;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(negedge clk);
        taken = out_ch.valid;
        @(posedge clk);
        if (taken) break;
      end
    end
  end

  initial begin
    int kind, ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, dx, dy;
    in_ch.valid = 1'b0;
    {in_ch.seg_a_start_x, in_ch.seg_a_start_y, in_ch.seg_a_end_x, in_ch.seg_a_end_y} = '0;
    {in_ch.seg_b_start_x, in_ch.seg_b_start_y, in_ch.seg_b_end_x, in_ch.seg_b_end_y} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: shared endpoints, zero denominator, extremes, plain crossings.
    send_pair(5, 7, 20, -3, 5, 7, 100, 100);          // a1 on b1
    send_pair(5, 7, 20, -3, -9, 4, 5, 7);             // a1 on b2
    send_pair(5, 7, 20, -3, 20, -3, 0, 0);            // a2 on b1
    send_pair(5, 7, 20, -3, 1, 1, 20, -3);            // a2 on b2
    send_pair(3, 3, 3, 3, 3, 3, 3, 3);                // everything one point
    send_pair(0, 0, 10, 10, 2, 2, 5, 5);              // collinear
    send_pair(1, 2, 8, 9, 4, 4, 4, 4);                // B is a point
    send_pair(0, 0, 10, 0, 5, -5, 5, 5);              // plain cross
    send_pair(-10, -10, 10, 10, -10, 10, 10, -10);
    send_pair(0, 0, 7, 3, 1, 5, 2, -4);
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_pair(32767, 32767, -32768, -32768, 32767, 0, -32768, 1);
    send_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
    send_pair(-1, -1, 0, 0, 32767, -32768, -32768, 32767);
    send_pair(0, 0, 1, 0, 0, 1, 1, 1);                // parallel, no touch
    send_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1);

    for (int n = 0; n < RandomPairs; n++) begin
      if (n % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      ax1 = any_coord(); ay1 = any_coord(); ax2 = any_coord(); ay2 = any_coord();
      bx1 = any_coord(); by1 = any_coord(); bx2 = any_coord(); by2 = any_coord();
      case (kind)
        4, 5: begin
          ax1 = near_coord(100); ay1 = near_coord(100);
          ax2 = near_coord(100); ay2 = near_coord(100);
          bx1 = near_coord(100); by1 = near_coord(100);
          bx2 = near_coord(100); by2 = near_coord(100);
        end
        6: begin
          // share one endpoint of A with one of B
          case ($urandom_range(0, 3))
            0: begin bx1 = ax1; by1 = ay1; end
            1: begin bx2 = ax1; by2 = ay1; end
            2: begin bx1 = ax2; by1 = ay2; end
            default: begin bx2 = ax2; by2 = ay2; end
          endcase
        end
        7: begin
          // A lying on the line of B, or B collapsed to a point
          bx1 = near_coord(1000); by1 = near_coord(1000);
          dx = near_coord(20); dy = near_coord(20);
          bx2 = bx1 + dx * near_coord(30); by2 = by1 + dy * near_coord(30);
          if ($urandom_range(0, 3) == 0) begin bx2 = bx1; by2 = by1; end
          else begin bx2 = bx1 + dx; by2 = by1 + dy; end
          ax1 = bx1 + dx * near_coord(40); ay1 = by1 + dy * near_coord(40);
          ax2 = bx1 + dx * near_coord(40); ay2 = by1 + dy * near_coord(40);
        end
        default: ;
      endcase
      send_pair(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
    end
    in_ch.valid <= 1'b0;

    // Drain, then give the pipeline its latency to show any stray beat.
    while (pending != 0) @(posedge clk);
    repeat (TF + 20) @(posedge clk);

    $display("Run covered %0d segment pairs end to end, %0d of them with a zero denominator,",
             beats_checked, degenerate_seen);
    $display("with random stalls on both channels and bursts at full rate.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
